// ===== design/vebss_pkg.sv =====
// vebss_pkg: shared types and constants for the van Emde Boas successor search unit
// beat structs, function codes and the controller/datapath command and status groups
// no dependencies
`default_nettype none

package vebss_pkg;

  localparam int LOG_LEAVES_DEF = 10;

  localparam logic [1:0] FN_CLEAR  = 2'd0;
  localparam logic [1:0] FN_LOAD   = 2'd1;
  localparam logic [1:0] FN_SEARCH = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [9:0]  leaf_index;
    logic [63:0] key_value;
  } in_beat_t;

  typedef struct packed {
    logic [9:0] position;
    logic       is_answer;
  } out_beat_t;

  typedef struct packed {
    logic take;
    logic addr_step;
    logic mem_rd;
    logic eval;
    logic clr_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic addr_done;
    logic walk_last;
    logic clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ===== design/vebss_dpath.sv =====
// vebss_dpath: node store, van Emde Boas address walker, key compare and result register
// driven by vebss_ctrl through vebss_pkg::cmd_t; uses vebss_pkg
`default_nettype none

module vebss_dpath #(
  parameter int LOG_LEAVES = vebss_pkg::LOG_LEAVES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire vebss_pkg::in_beat_t in_data,
  input  wire vebss_pkg::cmd_t     cmd,
  output vebss_pkg::sts_t          sts,
  output vebss_pkg::out_beat_t     out_data
);

  localparam int L      = LOG_LEAVES;
  localparam int LEVELS = L + 1;
  localparam int AW     = LEVELS;
  localparam int NODES  = 1 << AW;
  localparam int DW     = $clog2(LEVELS + 1);
  localparam logic [DW-1:0] D_LEAF   = DW'(L);
  localparam logic [DW-1:0] D_LEVELS = DW'(LEVELS);

  logic [63:0] mem [NODES];
  logic [63:0] rdata_r;

  // latched item
  logic [1:0]  func_r;
  logic [63:0] key_r;
  logic [L-1:0] pos_r;

  // current node as (depth, path bits)
  logic [DW-1:0] cur_d_r, cur_d_nxt;
  logic [L-1:0]  cur_r_r, cur_r_nxt;

  // address walker
  logic [DW-1:0] h_r, h_nxt;
  logic [DW-1:0] dd_r, dd_nxt;
  logic [L-1:0]  rr_r, rr_nxt;
  logic [AW-1:0] a_r, a_nxt;

  logic [AW-1:0] clr_cnt_r;

  logic [L+9:0]  leaf_ext;
  logic [L+9:0]  pos_ext;
  logic          go_right;
  logic [L-1:0]  r_fin;
  logic          is_search;
  logic          load_node;

  logic [DW-1:0] top, rest, sh, dd_new;
  logic [L-1:0]  sub_i;
  logic [AW:0]   one_w, i_w, add_w, a_w;

  logic          we;
  logic [AW-1:0] wa;
  logic [63:0]   wd;

  assign leaf_ext  = {{10{1'b0}}, in_data.leaf_index};
  assign is_search = (func_r == vebss_pkg::FN_SEARCH);
  assign go_right  = (key_r > rdata_r);
  assign r_fin     = cur_r_r | L'(go_right);

  assign sts.walk_last = is_search ? (cur_d_r == D_LEAF) : (cur_d_r == '0);
  assign sts.addr_done = (h_r <= DW'(1));
  assign sts.clr_last  = &clr_cnt_r;

  // next node
  always_comb begin
    cur_d_nxt = cur_d_r;
    cur_r_nxt = cur_r_r;
    load_node = 1'b0;
    if (cmd.take) begin
      load_node = 1'b1;
      if (in_data.func == vebss_pkg::FN_SEARCH) begin
        cur_d_nxt = DW'(1);
        cur_r_nxt = '0;
      end else begin
        cur_d_nxt = D_LEAF;
        cur_r_nxt = leaf_ext[L-1:0];
      end
    end else if (cmd.eval && !sts.walk_last) begin
      load_node = 1'b1;
      if (is_search) begin
        cur_d_nxt = cur_d_r + DW'(1);
        cur_r_nxt = r_fin << 1;
      end else begin
        cur_d_nxt = cur_d_r - DW'(1);
        cur_r_nxt = cur_r_r >> 1;
      end
    end
  end

  // one recursion step of the layout: either drop into the top half or into a bottom subtree
  always_comb begin
    top    = h_r >> 1;
    rest   = h_r - top;
    sh     = dd_r - top;
    sub_i  = rr_r >> sh;
    dd_new = sh;
    one_w  = {{AW{1'b0}}, 1'b1};
    i_w    = {{(AW+1-L){1'b0}}, sub_i};
    add_w  = ((one_w << top) - one_w) + (i_w << rest) - i_w;
    a_w    = {1'b0, a_r} + add_w;
    h_nxt  = h_r;
    dd_nxt = dd_r;
    rr_nxt = rr_r;
    a_nxt  = a_r;
    if (load_node) begin
      h_nxt  = D_LEVELS;
      dd_nxt = cur_d_nxt;
      rr_nxt = cur_r_nxt;
      a_nxt  = AW'(1);
    end else if (cmd.addr_step && !sts.addr_done) begin
      if (dd_r < top) begin
        h_nxt = top;
      end else begin
        h_nxt  = rest;
        dd_nxt = dd_new;
        rr_nxt = rr_r & ~({L{1'b1}} << dd_new);
        a_nxt  = a_w[AW-1:0];
      end
    end
  end

  // store write port
  always_comb begin
    we = 1'b0;
    wa = a_r;
    wd = key_r;
    if (cmd.clr_step) begin
      we = 1'b1;
      wa = clr_cnt_r;
      wd = '0;
    end else if (cmd.eval && (func_r == vebss_pkg::FN_LOAD)) begin
      we = (cur_d_r == D_LEAF) || go_right;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (cmd.mem_rd) begin
      rdata_r <= mem[a_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt_r <= clr_cnt_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    cur_d_r <= cur_d_nxt;
    cur_r_r <= cur_r_nxt;
    h_r     <= h_nxt;
    dd_r    <= dd_nxt;
    rr_r    <= rr_nxt;
    a_r     <= a_nxt;
    if (cmd.take) begin
      func_r <= in_data.func;
      key_r  <= in_data.key_value;
    end
    if (cmd.eval && is_search && sts.walk_last) begin
      pos_r <= r_fin;
    end
  end

  assign pos_ext = {{10{1'b0}}, pos_r};

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.position  <= is_search ? pos_ext[9:0] : 10'd0;
      out_data.is_answer <= is_search;
    end
  end

endmodule

`default_nettype wire

// ===== design/vebss_ctrl.sv =====
// vebss_ctrl: sequencer for clear sweeps, tree walks and result hand-off
// commands vebss_dpath through vebss_pkg::cmd_t; uses vebss_pkg
`default_nettype none

module vebss_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  input  wire logic [1:0]      in_func,
  output logic                 in_stall,
  output logic                 out_valid,
  input  wire logic            out_stall,
  input  wire vebss_pkg::sts_t sts,
  output vebss_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_WALK,
    S_RD,
    S_EV,
    S_FIN
  } state_t;

  state_t state_r;
  logic   reply_r;
  logic   out_valid_r;
  logic   accept;
  logic   out_free;

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    cmd.take      = accept;
    cmd.addr_step = (state_r == S_WALK);
    cmd.mem_rd    = (state_r == S_RD);
    cmd.eval      = (state_r == S_EV);
    cmd.clr_step  = (state_r == S_CLR);
    cmd.out_load  = (state_r == S_FIN) && out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      reply_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLR: begin
          if (sts.clr_last) begin
            state_r <= reply_r ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (in_func) inside
              vebss_pkg::FN_CLEAR: begin
                state_r <= S_CLR;
                reply_r <= 1'b1;
              end
              vebss_pkg::FN_LOAD, vebss_pkg::FN_SEARCH: state_r <= S_WALK;
              default: state_r <= S_FIN;
            endcase
          end
        end
        S_WALK: begin
          if (sts.addr_done) begin
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_EV;
        S_EV: state_r <= sts.walk_last ? S_FIN : S_WALK;
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
            reply_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/veb_layout_successor_search_unit.sv =====
// veb_layout_successor_search_unit: top level of the van Emde Boas layout successor search
// joins vebss_ctrl and vebss_dpath; uses vebss_pkg
//
//   channel | ports                          | beat
//   in      | in_valid, in_stall, in_data    | func, leaf_index, key_value
//   out     | out_valid, out_stall, out_data | position, is_answer
//
// one item at a time. each node visit costs the layout address walk plus one store read and
// one compare/write step: a search visits LOG_LEAVES nodes, a load LOG_LEAVES+1.
// a clear item sweeps the whole store; the same sweep runs after reset and no item is taken
// until it ends. a new item is taken while a result waits under stall.
`default_nettype none

module veb_layout_successor_search_unit #(
  parameter int LOG_LEAVES = vebss_pkg::LOG_LEAVES_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire vebss_pkg::in_beat_t in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output vebss_pkg::out_beat_t     out_data
);

  vebss_pkg::cmd_t cmd;
  vebss_pkg::sts_t sts;

  vebss_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_func   (in_data.func),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  vebss_dpath #(
    .LOG_LEAVES (LOG_LEAVES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

// ===== dv/tb_veb_layout_successor_search_unit.sv =====
// testbench for veb_layout_successor_search_unit: clear, load, search and unused-code beats with random idling
// holds a breadth-first max tree as the predictor and checks each result beat in order
// depends on vebss_pkg and the design top level
`timescale 1ns / 1ps
`default_nettype none

class succ_scoreboard;
  localparam int LEAVES = 1 << vebss_pkg::LOG_LEAVES_DEF;
  localparam int NODES  = 2 * LEAVES;
  localparam logic [1:0] FN_NONE = 2'd3;

  logic [63:0]          max_tree [NODES];
  vebss_pkg::out_beat_t want_q [$];
  int                   errors;
  int                   n_clear, n_load, n_search, n_none;

  function new();
    foreach (max_tree[i]) max_tree[i] = '0;
    errors = 0;
    n_clear = 0; n_load = 0; n_search = 0; n_none = 0;
  endfunction

  function logic [63:0] leaf_key(int leaf);
    return max_tree[LEAVES + leaf];
  endfunction

  // order of nodes in the store does not change behavior; breadth-first is enough here
  function void note_input(vebss_pkg::in_beat_t b);
    vebss_pkg::out_beat_t r;
    int node;
    r = '0;
    case (b.func)
      vebss_pkg::FN_CLEAR: begin
        foreach (max_tree[i]) max_tree[i] = '0;
        n_clear++;
      end
      vebss_pkg::FN_LOAD: begin
        node = LEAVES + int'(b.leaf_index);
        max_tree[node] = b.key_value;
        node = node >> 1;
        while (node != 0) begin
          if (b.key_value > max_tree[node]) max_tree[node] = b.key_value;
          node = node >> 1;
        end
        n_load++;
      end
      vebss_pkg::FN_SEARCH: begin
        node = 1;
        for (int lvl = 1; lvl <= vebss_pkg::LOG_LEAVES_DEF; lvl++)
          node = 2 * node + ((b.key_value > max_tree[2 * node]) ? 1 : 0);
        r.position  = 10'(node - LEAVES);
        r.is_answer = 1'b1;
        n_search++;
      end
      default: n_none++;
    endcase
    want_q.insert(want_q.size(), r);
  endfunction

  function void check_result(vebss_pkg::out_beat_t got);
    vebss_pkg::out_beat_t want;
    if (want_q.size() == 0) begin
      $display("%0t: unexpected result beat, actual %0d/%0b", $time, got.position,
               got.is_answer);
      errors++;
      return;
    end
    want = want_q.pop_front();
    if (got.position !== want.position) begin
      $display("%0t: position mismatch, expected %0d actual %0d", $time, want.position,
               got.position);
      errors++;
    end
    if (got.is_answer !== want.is_answer) begin
      $display("%0t: is_answer mismatch, expected %0b actual %0b", $time, want.is_answer,
               got.is_answer);
      errors++;
    end
  endfunction
endclass

module tb_veb_layout_successor_search_unit;
  localparam logic [1:0] FN_NONE = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  vebss_pkg::in_beat_t  in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  vebss_pkg::out_beat_t out_data;

  succ_scoreboard sb = new();
  int  tx_idle_pct = 0;
  int  rx_idle_pct = 0;
  bit  hold_req = 0;
  int  hold_left = 0;

  veb_layout_successor_search_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: check accepted beats, then pick next cycle's stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    if (hold_req) begin
      hold_req = 0;
      hold_left = 400;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= rst_n && ($urandom_range(99) < rx_idle_pct);
    end
  end

  task automatic send_beat(logic [1:0] fn, logic [9:0] leaf, logic [63:0] key);
    vebss_pkg::in_beat_t b;
    b.func = fn;
    b.leaf_index = leaf;
    b.key_value = key;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(b);
  endtask

  // search keys that land on, next to, or away from loaded leaves
  function automatic logic [63:0] pick_query();
    logic [63:0] k;
    k = sb.leaf_key($urandom_range(1023));
    case ($urandom_range(5))
      0: return k;
      1: return k + 1;
      2: return k - 1;
      3: return {$urandom, $urandom};
      4: return ($urandom_range(1)) ? 64'd0 : '1;
      default: return {10'($urandom_range(1023)), 22'($urandom), $urandom};
    endcase
  endfunction

  task automatic random_items(int count);
    int r;
    logic [9:0] leaf;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      leaf = 10'($urandom);
      if (r < 1)
        send_beat(vebss_pkg::FN_CLEAR, leaf, {$urandom, $urandom});
      else if (r < 4)
        send_beat(FN_NONE, leaf, {$urandom, $urandom});
      else if (r < 30)
        // mostly ascending keys so the leaves stay close to sorted
        send_beat(vebss_pkg::FN_LOAD, leaf, {leaf, 22'($urandom), $urandom});
      else if (r < 45)
        send_beat(vebss_pkg::FN_LOAD, leaf, {$urandom, $urandom});
      else
        send_beat(vebss_pkg::FN_SEARCH, leaf, pick_query());
    end
  endtask

  initial begin
    int wait_cnt;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_beat(vebss_pkg::FN_SEARCH, 10'd0, 64'd0);
    send_beat(FN_NONE, 10'h3ff, '1);
    send_beat(vebss_pkg::FN_LOAD, 10'd0, 64'd0);
    send_beat(vebss_pkg::FN_LOAD, 10'h3ff, '1);
    send_beat(vebss_pkg::FN_SEARCH, 10'h3ff, 64'd0);
    send_beat(vebss_pkg::FN_SEARCH, 10'd0, 64'd1);
    send_beat(vebss_pkg::FN_SEARCH, 10'd0, '1);
    send_beat(vebss_pkg::FN_LOAD, 10'h3ff, 64'd100);
    send_beat(vebss_pkg::FN_LOAD, 10'd512, 64'd50);
    send_beat(vebss_pkg::FN_SEARCH, 10'd0, 64'd50);
    send_beat(vebss_pkg::FN_SEARCH, 10'd0, 64'd51);
    send_beat(vebss_pkg::FN_SEARCH, 10'd0, '1);
    send_beat(vebss_pkg::FN_CLEAR, 10'h2aa, 64'h5555_5555_5555_5555);
    send_beat(vebss_pkg::FN_LOAD, 10'h155, 64'haaaa_aaaa_aaaa_aaaa);
    send_beat(vebss_pkg::FN_LOAD, 10'h2aa, 64'h5555_5555_5555_5555);
    send_beat(vebss_pkg::FN_SEARCH, 10'h3ff, 64'h5555_5555_5555_5556);
    send_beat(vebss_pkg::FN_SEARCH, 10'h3ff, 64'hffff_ffff_ffff_fffe);
    send_beat(FN_NONE, 10'd0, 64'd0);
    send_beat(vebss_pkg::FN_CLEAR, 10'd0, 64'd0);

    tx_idle_pct = 31; rx_idle_pct = 84;
    random_items(235);
    tx_idle_pct = 84; rx_idle_pct = 31;
    random_items(235);
    tx_idle_pct = 0; rx_idle_pct = 0;
    hold_req = 1;
    random_items(235);
    in_valid <= 1'b0;

    wait_cnt = 0;
    while (sb.want_q.size() != 0 && wait_cnt < 100000) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (200) @(posedge clk);
    if (sb.want_q.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, sb.want_q.size());
      sb.errors++;
    end
    $display("covered %0d clears, %0d loads, %0d searches, %0d unused codes",
             sb.n_clear, sb.n_load, sb.n_search, sb.n_none);
    $display("under sender/receiver idling in both orders plus a long receiver hold");
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end
endmodule

`default_nettype wire
